/* sv/aarmv_pkg.sv */
`default_nettype none

package aarmv_pkg;

    // field widths
    localparam int SRC_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int MV_W     = 12;

    // a batch holds at most 256 samples
    localparam int CNT_W = 9;
    localparam int SUM_W = SAMPLE_W + 8;

    // quotient of avg*100/65535 never exceeds 100
    localparam int PCT_W = 7;

    // widest dividend: signal average times the reference span
    localparam int DIV_W  = SAMPLE_W + MV_W;
    localparam int DSR_W  = 16;

    // rounded-up reciprocal of a batch size, exact for any sum below 2**SUM_W
    // as long as the batch holds at most 256 samples
    localparam int RCP_SHIFT = SUM_W + 8;
    localparam int RCP_W     = RCP_SHIFT + 1;

    localparam int DEF_SIGNAL_SAMPLES   = 16;
    localparam int DEF_REF_HIGH_SAMPLES = 16;
    localparam int DEF_REF_LOW_SAMPLES  = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DSR_W-1:0] FULL_SCALE = 16'hFFFF;
    localparam logic [MV_W-1:0]  MV_SCALE   = 12'd33;
    localparam logic [PCT_W-1:0] PCT_SCALE  = 7'd100;

    // source codes
    localparam logic [SRC_W-1:0] SRC_SIGNAL   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_REF_HIGH = 2'd1;
    localparam logic [SRC_W-1:0] SRC_REF_LOW  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_NONE     = 2'd3;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [SUM_W-1:0] sum;
    } t_queue_entry;

    typedef struct packed {
        logic             start;
        logic             by_full;
        logic [DIV_W-1:0] dividend;
        logic [RCP_W-1:0] recip;
    } t_div_req;

endpackage

`default_nettype wire

/* sv/aarmv_in_if.sv */
`default_nettype none

interface aarmv_in_if;
    import aarmv_pkg::*;

    logic                valid;
    logic                ready;
    logic [SRC_W-1:0]    source;
    logic [SAMPLE_W-1:0] sample_value;

    modport source_port (output valid, source, sample_value, input ready);
    modport sink_port   (input valid, source, sample_value, output ready);
endinterface

`default_nettype wire

/* sv/aarmv_out_if.sv */
`default_nettype none

interface aarmv_out_if;
    import aarmv_pkg::*;

    logic                valid;
    logic                ready;
    logic [MV_W-1:0]     millivolts;
    logic [SAMPLE_W-1:0] signal_average;
    logic [MV_W-1:0]     ref_high_mv;
    logic [MV_W-1:0]     ref_low_mv;

    modport source_port (output valid, millivolts, signal_average, ref_high_mv, ref_low_mv,
                         input ready);
    modport sink_port   (input valid, millivolts, signal_average, ref_high_mv, ref_low_mv,
                         output ready);
endinterface

`default_nettype wire

/* sv/aarmv_front.sv */
`default_nettype none

module aarmv_front #(
    parameter int SIGNAL_SAMPLES   = aarmv_pkg::DEF_SIGNAL_SAMPLES,
    parameter int REF_HIGH_SAMPLES = aarmv_pkg::DEF_REF_HIGH_SAMPLES,
    parameter int REF_LOW_SAMPLES  = aarmv_pkg::DEF_REF_LOW_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    aarmv_in_if.sink_port              i_in,
    input  wire logic                  i_full,
    output logic                       o_push,
    output aarmv_pkg::t_queue_entry    o_push_data
);
    import aarmv_pkg::*;

    localparam logic [CNT_W-1:0] N_SIG = CNT_W'(SIGNAL_SAMPLES);
    localparam logic [CNT_W-1:0] N_HI  = CNT_W'(REF_HIGH_SAMPLES);
    localparam logic [CNT_W-1:0] N_LO  = CNT_W'(REF_LOW_SAMPLES);

    logic [SUM_W-1:0] r_sum [3];
    logic [CNT_W-1:0] r_cnt [3];

    logic             accept;
    logic             live;
    logic [1:0]       idx;
    logic [CNT_W-1:0] batch_n;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic             batch_done;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign live       = (i_in.source != SRC_NONE);
    assign idx        = live ? i_in.source : SRC_SIGNAL;

    always_comb begin
        unique case (i_in.source)
            SRC_SIGNAL:   batch_n = N_SIG;
            SRC_REF_HIGH: batch_n = N_HI;
            default:      batch_n = N_LO;
        endcase
    end

    assign n_sum      = r_sum[idx] + SUM_W'(i_in.sample_value);
    assign n_cnt      = r_cnt[idx] + CNT_W'(1);
    assign batch_done = (n_cnt >= batch_n);

    assign o_push          = accept && live && batch_done;
    assign o_push_data.src = i_in.source;
    assign o_push_data.sum = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else if (accept && live) begin
            if (batch_done) begin
                r_sum[idx] <= '0;
                r_cnt[idx] <= '0;
            end else begin
                r_sum[idx] <= n_sum;
                r_cnt[idx] <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/aarmv_fifo.sv */
`default_nettype none

module aarmv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = aarmv_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_pop_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/aarmv_div.sv */
`default_nettype none

module aarmv_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire aarmv_pkg::t_div_req      i_req,
    output logic                          o_done,
    output logic [aarmv_pkg::DIV_W-1:0]   o_quot
);
    import aarmv_pkg::*;

    localparam int FW = DIV_W + 1;
    localparam int PW = SUM_W + RCP_W;

    logic              r_busy;
    logic              r_done;
    logic              r_by_full;
    logic [DIV_W-1:0]  r_dvd;
    logic [RCP_W-1:0]  r_rcp;
    logic [DIV_W-1:0]  r_quot;

    logic [PW-1:0]     prod;
    logic [FW-1:0]     fold;
    logic [DIV_W-1:0]  quot;

    // batch average: multiply by the reciprocal and keep the high part
    assign prod = r_dvd[SUM_W-1:0] * r_rcp;

    // division by 65535 as (x + (x >> 16) + 1) >> 16
    assign fold = {1'b0, r_dvd} + FW'(r_dvd[DIV_W-1:DSR_W]) + FW'(1);

    assign quot = r_by_full ? DIV_W'(fold[FW-1:DSR_W]) : DIV_W'(prod[PW-1:RCP_SHIFT]);

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd     <= i_req.dividend;
            r_rcp     <= i_req.recip;
            r_by_full <= i_req.by_full;
        end
        if (r_busy) begin
            r_quot <= quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_req.start;
            r_done <= r_busy;
        end
    end

endmodule

`default_nettype wire

/* sv/aarmv_back.sv */
`default_nettype none

module aarmv_back #(
    parameter int SIGNAL_SAMPLES   = aarmv_pkg::DEF_SIGNAL_SAMPLES,
    parameter int REF_HIGH_SAMPLES = aarmv_pkg::DEF_REF_HIGH_SAMPLES,
    parameter int REF_LOW_SAMPLES  = aarmv_pkg::DEF_REF_LOW_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_empty,
    input  wire aarmv_pkg::t_queue_entry i_entry,
    output logic                       o_pop,
    aarmv_out_if.source_port           o_out
);
    import aarmv_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_AVG_WAIT  = 3'd1;
    localparam logic [2:0] ST_MV_START  = 3'd2;
    localparam logic [2:0] ST_MV_WAIT   = 3'd3;
    localparam logic [2:0] ST_OUT_START = 3'd4;
    localparam logic [2:0] ST_OUT_WAIT  = 3'd5;
    localparam logic [2:0] ST_EMIT      = 3'd6;

    // rounded-up reciprocals of the batch sizes
    localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SHIFT;
    localparam logic [RCP_W-1:0] R_SIG =
        RCP_W'((RCP_ONE + 64'(SIGNAL_SAMPLES) - 64'd1) / 64'(SIGNAL_SAMPLES));
    localparam logic [RCP_W-1:0] R_HI  =
        RCP_W'((RCP_ONE + 64'(REF_HIGH_SAMPLES) - 64'd1) / 64'(REF_HIGH_SAMPLES));
    localparam logic [RCP_W-1:0] R_LO  =
        RCP_W'((RCP_ONE + 64'(REF_LOW_SAMPLES) - 64'd1) / 64'(REF_LOW_SAMPLES));

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [SRC_W-1:0]    r_src;
    logic [SAMPLE_W-1:0] r_avg;
    logic [SAMPLE_W-1:0] r_sig_avg;
    logic [MV_W-1:0]     r_ref_high;
    logic [MV_W-1:0]     r_low_mv;
    logic [MV_W-1:0]     r_res_mv;

    logic                r_valid;
    logic [MV_W-1:0]     r_o_mv;
    logic [SAMPLE_W-1:0] r_o_sig;
    logic [MV_W-1:0]     r_o_hi;
    logic [MV_W-1:0]     r_o_lo;

    t_div_req            div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;
    logic [RCP_W-1:0]    batch_rcp;
    logic [MV_W-1:0]     span;
    logic [MV_W-1:0]     mv_calc;
    logic                out_free;

    aarmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        unique case (i_entry.src)
            SRC_SIGNAL:   batch_rcp = R_SIG;
            SRC_REF_HIGH: batch_rcp = R_HI;
            default:      batch_rcp = R_LO;
        endcase
    end

    // negative reference span saturates to zero
    assign span     = (r_ref_high > r_low_mv) ? (r_ref_high - r_low_mv) : '0;
    assign mv_calc  = MV_W'(div_quot[PCT_W-1:0]) * MV_SCALE;
    assign out_free = !r_valid || o_out.ready;

    always_comb begin
        n_state          = r_state;
        o_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.by_full  = 1'b0;
        div_req.dividend = DIV_W'(i_entry.sum);
        div_req.recip    = batch_rcp;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop         = 1'b1;
                    div_req.start = 1'b1;
                    n_state       = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    n_state = (r_src == SRC_SIGNAL) ? ST_IDLE : ST_MV_START;
                end
            end
            ST_MV_START: begin
                div_req.start    = 1'b1;
                div_req.by_full  = 1'b1;
                div_req.dividend = DIV_W'(r_avg) * DIV_W'(PCT_SCALE);
                n_state          = ST_MV_WAIT;
            end
            ST_MV_WAIT: begin
                if (div_done) begin
                    n_state = (r_src == SRC_REF_HIGH) ? ST_IDLE : ST_OUT_START;
                end
            end
            ST_OUT_START: begin
                div_req.start    = 1'b1;
                div_req.by_full  = 1'b1;
                div_req.dividend = DIV_W'(r_sig_avg) * DIV_W'(span);
                n_state          = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_sig_avg  <= '0;
            r_ref_high <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_AVG_WAIT && div_done && r_src == SRC_SIGNAL) begin
                r_sig_avg <= div_quot[SAMPLE_W-1:0];
            end
            if (r_state == ST_MV_WAIT && div_done && r_src == SRC_REF_HIGH) begin
                r_ref_high <= mv_calc;
            end
            if (r_state == ST_EMIT && out_free) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && !i_empty) begin
            r_src <= i_entry.src;
        end
        if (r_state == ST_AVG_WAIT && div_done) begin
            r_avg <= div_quot[SAMPLE_W-1:0];
        end
        if (r_state == ST_MV_WAIT && div_done) begin
            r_low_mv <= mv_calc;
        end
        if (r_state == ST_OUT_WAIT && div_done) begin
            r_res_mv <= div_quot[MV_W-1:0];
        end
        if (r_state == ST_EMIT && out_free) begin
            r_o_mv  <= r_res_mv;
            r_o_sig <= r_sig_avg;
            r_o_hi  <= r_ref_high;
            r_o_lo  <= r_low_mv;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.millivolts     = r_o_mv;
    assign o_out.signal_average = r_o_sig;
    assign o_out.ref_high_mv    = r_o_hi;
    assign o_out.ref_low_mv     = r_o_lo;

endmodule

`default_nettype wire

/* sv/adc_average_ratiometric_mv.sv */
// Oversampling ADC averager with ratiometric millivolt output. Each input word is one 16-bit
// sample tagged as signal (0), high reference (1) or low reference (2); tag 3 is accepted and
// dropped. Samples of each source are summed until that source's batch size is reached, then
// the batch sum goes through a two-entry queue to the arithmetic side, which forms the
// truncated average. A signal batch updates the stored signal average; a reference batch is
// scaled to millivolts as 33*((avg*100)/65535). A finished low-reference batch produces one
// output word: signal_avg*(vrefh_mv - vrefl_mv)/65535 in millivolts, together with the
// signal average and the two reference millivolt values it was built from; a low reference
// above the high reference gives 0 mV. Before any batch has finished, the stored values read
// as 0. Timing: the input side takes one word per cycle while the queue has room. The
// arithmetic side uses one shared constant divider (multiply by the batch size's reciprocal
// for the average, shift and add for the division by 65535), so a finished batch occupies it
// for the average (signal), the average and millivolt scaling (high reference), or both plus
// the ratiometric division and the wait for the output register to be taken (low reference).
// The input stalls only when two finished batches are already waiting in the queue. Batch
// sizes are set by the three *_SAMPLES parameters, 1 to 256 each.

`default_nettype none

module adc_average_ratiometric_mv #(
    parameter int SIGNAL_SAMPLES   = aarmv_pkg::DEF_SIGNAL_SAMPLES,
    parameter int REF_HIGH_SAMPLES = aarmv_pkg::DEF_REF_HIGH_SAMPLES,
    parameter int REF_LOW_SAMPLES  = aarmv_pkg::DEF_REF_LOW_SAMPLES
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    aarmv_in_if.sink_port     i_in,
    aarmv_out_if.source_port  o_out
);
    import aarmv_pkg::*;

    localparam int QW = $bits(t_queue_entry);

    // front to queue
    logic         push;
    t_queue_entry push_data;
    logic         q_full;

    // queue to back
    logic         pop;
    logic         q_empty;
    logic [QW-1:0] pop_bits;
    t_queue_entry pop_data;

    assign pop_data = t_queue_entry'(pop_bits);

    // accumulation side: per-source sum and count
    aarmv_front #(
        .SIGNAL_SAMPLES   (SIGNAL_SAMPLES),
        .REF_HIGH_SAMPLES (REF_HIGH_SAMPLES),
        .REF_LOW_SAMPLES  (REF_LOW_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // finished batches wait here while the divider is busy
    aarmv_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_bits),
        .o_empty     (q_empty)
    );

    // averaging, millivolt scaling and ratiometric output
    aarmv_back #(
        .SIGNAL_SAMPLES   (SIGNAL_SAMPLES),
        .REF_HIGH_SAMPLES (REF_HIGH_SAMPLES),
        .REF_LOW_SAMPLES  (REF_LOW_SAMPLES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_entry (pop_data),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
